// File: rtl/cag_pkg.sv
package cag_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned PASS_CFG_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT  = 2'd2;

  // Register reset values
  localparam int unsigned RST_GRID_WIDTH  = 64;
  localparam int unsigned RST_GRID_HEIGHT = 64;
  localparam int unsigned RST_PASS_COUNT  = 1;

  // Input item kinds
  localparam logic MODE_CELL  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Automaton rule: a wall survives on 4..5 wall neighbours, floor turns wall on 5+
  localparam logic [3:0] SURVIVE_MIN = 4'd4;
  localparam logic [3:0] SURVIVE_MAX = 4'd5;
  localparam logic [3:0] BIRTH_MIN   = 4'd5;

  // Item moving down the generation chain
  typedef struct packed {
    logic has;   // carries a cell
    logic wall;  // cell value
    logic last;  // final cell of the grid
  } token_t;

endpackage

// File: rtl/cag_ram.sv
module cag_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port (read returns old data on a clash)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cag_stage.sv
module cag_stage #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned TOT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  logic            active_i,
  input  logic [WW-1:0]   width_i,
  input  logic [HW-1:0]   height_i,
  input  logic [TOT_W-1:0] total_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cag_pkg::token_t in_tok_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cag_pkg::token_t out_tok_o
);

  import cag_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);

  // Stream position of the next cell shifted in, and the centre cell's coordinates
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CW-1:0]    wcol_q, wcol_d;
  logic [CW-1:0]    ccol_q, ccol_d;
  logic [RW-1:0]    crow_q, crow_d;

  // 3x3 window, each column {bottom, middle, top}
  logic [2:0] win_l_q, win_c_q, win_r_q;

  logic   out_vld_q, out_vld_d;
  token_t out_tok_q, out_tok_d;

  logic       byp_q;
  logic [1:0] byp_dat_q;
  logic [1:0] ram_rd, row_rd, ram_wd;

  logic [POS_W-1:0] total_ext, w_plus1, drain_end;
  logic framed, aligned, catchup, take, store, drain, shift, emit, fin;
  logic new_bit;
  logic [2:0] new_col, sl, sc, sr;
  logic top_out, bot_out, left_out, right_out;
  logic [7:0] nbr;
  logic [3:0] nbr_cnt;
  logic       next_wall;
  logic       wcol_wrap, ccol_wrap;

  // Frame progress
  assign total_ext = POS_W'(total_i);
  assign w_plus1   = POS_W'(width_i) + POS_W'(1);
  assign drain_end = POS_W'(total_i) + POS_W'(width_i);
  assign framed    = (pos_q >= total_ext);
  assign aligned   = (pos_q >= w_plus1);

  // Small grids: realign the window to the first cell before draining
  assign catchup    = active_i && framed && !aligned;
  assign in_ready_o = !catchup && (!out_vld_q || out_ready_i);
  assign take       = in_valid_i && in_ready_o;

  assign store = take && active_i && !framed && in_tok_i.has;
  assign drain = take && active_i && framed;
  assign shift = store || drain || catchup;
  assign emit  = (store && aligned) || drain;
  assign fin   = drain && (pos_q == drain_end);

  // Line store: bit 0 holds the cell one row up, bit 1 two rows up
  assign row_rd  = byp_q ? byp_dat_q : ram_rd;
  assign new_bit = store ? in_tok_i.wall : 1'b0;
  assign new_col = {new_bit, row_rd[0], row_rd[1]};
  assign ram_wd  = {row_rd[0], new_bit};

  // Window after this shift
  assign sl = win_c_q;
  assign sc = win_r_q;
  assign sr = new_col;

  // Grid border: outside cells count as walls
  assign top_out   = (crow_q == '0);
  assign bot_out   = (crow_q == RW'(height_i - 1'b1));
  assign left_out  = (ccol_q == '0);
  assign right_out = (ccol_q == CW'(width_i - 1'b1));

  assign nbr[0] = top_out || left_out  || sl[0];
  assign nbr[1] = top_out              || sc[0];
  assign nbr[2] = top_out || right_out || sr[0];
  assign nbr[3] = left_out             || sl[1];
  assign nbr[4] = right_out            || sr[1];
  assign nbr[5] = bot_out || left_out  || sl[2];
  assign nbr[6] = bot_out              || sc[2];
  assign nbr[7] = bot_out || right_out || sr[2];

  assign nbr_cnt   = 4'($countones(nbr));
  assign next_wall = sc[1] ? ((nbr_cnt == SURVIVE_MIN) || (nbr_cnt == SURVIVE_MAX))
                           : (nbr_cnt >= BIRTH_MIN);

  assign wcol_wrap = (wcol_q == CW'(width_i - 1'b1));
  assign ccol_wrap = right_out;

  // Counter updates
  always_comb begin
    pos_d  = pos_q;
    wcol_d = wcol_q;
    ccol_d = ccol_q;
    crow_d = crow_q;
    if (clear_i || fin) begin
      pos_d  = '0;
      wcol_d = '0;
      ccol_d = '0;
      crow_d = '0;
    end else begin
      if (shift) begin
        pos_d  = pos_q + POS_W'(1);
        wcol_d = wcol_wrap ? '0 : wcol_q + CW'(1);
      end
      if (emit) begin
        if (ccol_wrap) begin
          ccol_d = '0;
          crow_d = crow_q + RW'(1);
        end else begin
          ccol_d = ccol_q + CW'(1);
        end
      end
    end
  end

  // Output slot
  always_comb begin
    out_vld_d = out_vld_q;
    out_tok_d = out_tok_q;
    if (clear_i) begin
      out_vld_d = 1'b0;
    end else if (take) begin
      out_vld_d = 1'b1;
      if (active_i) begin
        out_tok_d.has  = emit;
        out_tok_d.wall = next_wall;
        out_tok_d.last = fin;
      end else begin
        out_tok_d = in_tok_i;
      end
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      wcol_q    <= '0;
      ccol_q    <= '0;
      crow_q    <= '0;
      out_vld_q <= 1'b0;
      byp_q     <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      wcol_q    <= wcol_d;
      ccol_q    <= ccol_d;
      crow_q    <= crow_d;
      out_vld_q <= out_vld_d;
      byp_q     <= shift && (wcol_d == wcol_q);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_tok_q <= out_tok_d;
    byp_dat_q <= ram_wd;
    if (shift) begin
      win_l_q <= sl;
      win_c_q <= sc;
      win_r_q <= sr;
    end
  end

  // Two-row line store, read one cell ahead
  cag_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (shift),
    .waddr_i (wcol_q),
    .wdata_i (ram_wd),
    .raddr_i (wcol_d),
    .rdata_o (ram_rd)
  );

  assign out_valid_o = out_vld_q;
  assign out_tok_o   = out_tok_q;

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> (pos_q == '0) && !out_vld_q)
    else $error("stage not cleared after a register write");

  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> (pos_q == '0) && (crow_q == '0) && (ccol_q == '0))
    else $error("stage counters not rewound after the last cell");

  a_wcol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wcol_q < width_i) && (ccol_q < width_i))
    else $error("column pointer beyond the grid width");

  a_crow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crow_q < height_i)
    else $error("centre row beyond the grid height");

endmodule

// File: rtl/cave_automaton_generation_unit.sv
// Cave automaton generation unit.
// Input channel (in_valid_i/in_ready_o): one transfer per grid cell in raster
// order (mode_i = cell), or a flush (mode_i = flush) that drains pending cells.
// Output channel (out_valid_o/out_ready_i): evolved cells in raster order,
// frame_last_o set on the final cell of the grid.
// Configuration: cfg_we_i writes grid width, grid height or pass count at
// cfg_index_i; any such write clears every generation and counter.
// Throughput: one transfer per cycle unless the receiver stalls or a window is
// realigned. Each generation is one cell of the chain with its own two-row line
// store, so a stage emits cell q once cell q+W+1 is in; the remaining W+1 cells
// of each generation come out on flush items. Every chain cell adds one
// register whether it applies a generation or not. Single-row grids hold off
// input in each generation once the row is in, while the window is realigned.
// Reset: 64 x 64 grid, one pass, empty chain; no store clearing is needed.
// Receiver stall: the output register holds its result; the chain keeps taking
// transfers until its cell registers fill, then in_ready_o drops.
module cave_automaton_generation_unit #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_PASSES = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cag_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cag_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             mode_i,
  input  logic                             cell_is_wall_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             result_is_wall_o,
  output logic                             frame_last_o
);

  import cag_pkg::*;

  localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW     = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned TOT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned PASS_W = $clog2(MAX_PASSES + 1);
  localparam int unsigned RST_W  = (RST_GRID_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_GRID_WIDTH;
  localparam int unsigned RST_H  = (RST_GRID_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                                  : RST_GRID_HEIGHT;
  localparam int unsigned RST_P  = (RST_PASS_COUNT > MAX_PASSES) ? MAX_PASSES
                                                                 : RST_PASS_COUNT;

  logic [WW-1:0]     width_q, w_cfg, mul_a;
  logic [HW-1:0]     height_q, h_cfg, mul_b;
  logic [WW+HW-1:0]  prod;
  logic [TOT_W-1:0]  total_q;
  logic [PASS_W-1:0] passes_q, p_cfg;
  logic [TOT_W-1:0]  cnt_q, cnt_d;
  logic              cfg_is_w, cfg_is_h, cfg_is_p, clear;
  logic              zero_pass, in_xfer, cnt_last;
  logic              out_vld_q, out_vld_d;
  logic              res_wall_q, res_last_q;

  token_t                  tok     [MAX_PASSES+1];
  logic [MAX_PASSES:0]     tok_vld;
  logic [MAX_PASSES:0]     tok_rdy;
  logic [MAX_PASSES-1:0]   active;

  // Register write decode
  assign cfg_is_w = cfg_we_i && (cfg_index_i == REG_GRID_WIDTH);
  assign cfg_is_h = cfg_we_i && (cfg_index_i == REG_GRID_HEIGHT);
  assign cfg_is_p = cfg_we_i && (cfg_index_i == REG_PASS_COUNT);
  assign clear    = cfg_is_w || cfg_is_h || cfg_is_p;

  // Clamp written values to the supported range
  always_comb begin
    if (cfg_data_i == '0) begin
      w_cfg = WW'(1);
      h_cfg = HW'(1);
    end else begin
      w_cfg = (int'(cfg_data_i) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(cfg_data_i);
      h_cfg = (int'(cfg_data_i) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data_i);
    end
    p_cfg = (int'(cfg_data_i[PASS_CFG_W-1:0]) > MAX_PASSES)
            ? PASS_W'(MAX_PASSES) : PASS_W'(cfg_data_i[PASS_CFG_W-1:0]);
  end

  // Cell count of the grid, taken at the register write
  assign mul_a = cfg_is_w ? w_cfg : width_q;
  assign mul_b = cfg_is_h ? h_cfg : height_q;
  assign prod  = {{HW{1'b0}}, mul_a} * {{WW{1'b0}}, mul_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(RST_W);
      height_q <= HW'(RST_H);
      total_q  <= TOT_W'(RST_W * RST_H);
      passes_q <= PASS_W'(RST_P);
    end else begin
      if (cfg_is_w) begin
        width_q <= w_cfg;
      end
      if (cfg_is_h) begin
        height_q <= h_cfg;
      end
      if (cfg_is_w || cfg_is_h) begin
        total_q <= prod[TOT_W-1:0];
      end
      if (cfg_is_p) begin
        passes_q <= p_cfg;
      end
    end
  end

  // Pass-through counting when no generation is applied
  assign zero_pass = (passes_q == '0);
  assign in_xfer   = in_valid_i && in_ready_o;
  assign cnt_last  = ((cnt_q + TOT_W'(1)) == total_q);

  always_comb begin
    cnt_d = cnt_q;
    if (clear) begin
      cnt_d = '0;
    end else if (in_xfer && zero_pass && (mode_i == MODE_CELL)) begin
      cnt_d = cnt_last ? '0 : cnt_q + TOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Chain input
  assign tok[0].has  = (mode_i == MODE_CELL);
  assign tok[0].wall = cell_is_wall_i;
  assign tok[0].last = zero_pass && (mode_i == MODE_CELL) && cnt_last;
  assign tok_vld[0]  = in_valid_i;
  assign in_ready_o  = tok_rdy[0];

  // One chain cell per generation
  for (genvar k = 0; k < MAX_PASSES; k++) begin : g_gen
    assign active[k] = (PASS_W'(k) < passes_q);

    cag_stage #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .clear_i     (clear),
      .active_i    (active[k]),
      .width_i     (width_q),
      .height_i    (height_q),
      .total_i     (total_q),
      .in_valid_i  (tok_vld[k]),
      .in_ready_o  (tok_rdy[k]),
      .in_tok_i    (tok[k]),
      .out_valid_o (tok_vld[k+1]),
      .out_ready_i (tok_rdy[k+1]),
      .out_tok_o   (tok[k+1])
    );
  end

  // Output register; items without a cell are dropped here
  assign tok_rdy[MAX_PASSES] = !out_vld_q || out_ready_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (tok_vld[MAX_PASSES] && tok_rdy[MAX_PASSES] && tok[MAX_PASSES].has) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_vld[MAX_PASSES] && tok_rdy[MAX_PASSES] && tok[MAX_PASSES].has) begin
      res_wall_q <= tok[MAX_PASSES].wall;
      res_last_q <= tok[MAX_PASSES].last;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign result_is_wall_o = res_wall_q;
  assign frame_last_o     = res_last_q;

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < total_q)
    else $error("pass-through count reached the grid size");

  a_geom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_q != '0) && (height_q != '0) && (total_q != '0))
    else $error("empty grid geometry");

  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (cnt_q == '0) && (int'(passes_q) <= MAX_PASSES))
    else $error("register write did not leave a clean pass setup");

endmodule
